// ===== rtl/mfr_pkg.sv =====
// Shared types and constants for the meter frame receiver.
package mfr_pkg;

    // Number of address bytes in a frame header
    localparam int ADDRESS_BYTES = 7;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int POS_W     = 9;
    localparam int TICK_W    = 16;
    localparam int CLASS_W   = 3;
    localparam int EVENT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int OUT_DAT_W = 24;

    // Request kinds on the input channel
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Field class codes (also the parser phase encoding)
    localparam logic [CLASS_W-1:0] CLS_START = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_TYPE  = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_ADDR  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_CTRL  = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_LEN   = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_DATA  = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_SUM   = 3'd6;
    localparam logic [CLASS_W-1:0] CLS_END   = 3'd7;

    // Frame event codes
    localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_FRAME_OK  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_SUM_ERR   = 3'd2;
    localparam logic [EVENT_W-1:0] EV_END_ERR   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOF_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EOF_BYTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] SOF_BYTE_RST = 8'd104;
    localparam logic [BYTE_W-1:0] EOF_BYTE_RST = 8'd22;
    localparam logic [TICK_W-1:0] TIMEOUT_RST  = 16'd100;

    typedef struct packed {
        logic [BYTE_W-1:0] sof_byte;
        logic [BYTE_W-1:0] eof_byte;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic               byte_valid;
        logic [BYTE_W-1:0]  byte_value;
        logic [CLASS_W-1:0] byte_class;
        logic [POS_W-1:0]   byte_index;
        logic [EVENT_W-1:0] frame_event;
    } result_t;

endpackage

// ===== rtl/meter_frame_receiver.sv =====
// Top level of the meter-bus frame receiver.
//
// Input channel (s_*): one transaction per request. s_tuser = 1 is a time
// tick, s_tuser = 0 carries a received byte in s_tdata. Bytes of a frame
// are start mark, type, address bytes, control, length, data, checksum
// (8-bit sum of all earlier frame bytes) and end mark.
// Output channel (m_*): exactly one transaction per input transaction.
// m_tuser flags a byte taken into a frame; m_tdata carries the echoed byte,
// its field class, its position in the frame and the frame event.
// Config port: cfg_we writes cfg_data into register cfg_index (0 start
// mark, 1 end mark, 2 timeout ticks); write only while the block is idle.
// The result is registered; throughput is one transaction per cycle while the
// sink does not stall, set by the single parse stage feeding the result
// register. s_tready stays high while the result register is empty or is
// being drained; when the sink stalls with a result held, s_tready drops
// and the parser state holds.
// Reset clears the parser to start-mark hunting, the idle timer to zero,
// the output valid, and loads the register defaults (0x68, 0x16, 100).
module meter_frame_receiver
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mfr_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  logic                           s_tuser,   // [0] req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] byte_value, [10:8] byte_class, [19:11] byte_index,
    // [22:20] frame_event, [23] zero
    output logic [mfr_pkg::OUT_DAT_W-1:0]  m_tdata,
    output logic                           m_tuser,   // [0] byte_valid
    input  logic                           cfg_we,
    input  logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfr_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import mfr_pkg::*;

    cfg_t    cfg;
    result_t result;
    logic    ready;
    logic    accept;

    assign s_tready = ready;
    assign accept   = s_tvalid && ready;

    mfr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Parser state advances only on an accepted transaction
    mfr_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .load     (accept),
        .req_type (s_tuser),
        .rx_byte  (s_tdata),
        .result   (result)
    );

    mfr_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .ready    (ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/mfr_cfg_regs.sv =====
// Configuration register bank of the meter frame receiver.
module mfr_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfr_pkg::CFG_DAT_W-1:0]  cfg_data,
    output mfr_pkg::cfg_t                  cfg
);
    import mfr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_byte      <= SOF_BYTE_RST;
            cfg_reg.eof_byte      <= EOF_BYTE_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOF_BYTE: cfg_reg.sof_byte      <= cfg_data[BYTE_W-1:0];
                REG_EOF_BYTE: cfg_reg.eof_byte      <= cfg_data[BYTE_W-1:0];
                REG_TIMEOUT:  cfg_reg.timeout_ticks <= cfg_data[TICK_W-1:0];
                default:      ; // unused index: drop the write
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/mfr_parser.sv =====
// Frame parser: field state machine, checksum, position and idle timer.
module mfr_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mfr_pkg::cfg_t               cfg,
    input  logic                        load,
    input  logic                        req_type,
    input  logic [mfr_pkg::BYTE_W-1:0]  rx_byte,
    output mfr_pkg::result_t            result
);
    import mfr_pkg::*;

    typedef enum logic [CLASS_W-1:0] {
        PH_START = CLS_START,
        PH_TYPE  = CLS_TYPE,
        PH_ADDR  = CLS_ADDR,
        PH_CTRL  = CLS_CTRL,
        PH_LEN   = CLS_LEN,
        PH_DATA  = CLS_DATA,
        PH_SUM   = CLS_SUM,
        PH_END   = CLS_END
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  field_count_reg, field_count_next;
    logic [BYTE_W-1:0]   payload_length_reg, payload_length_next;
    logic [BYTE_W-1:0]   running_sum_reg, running_sum_next;
    logic [POS_W-1:0]    frame_position_reg, frame_position_next;
    logic [TICK_W-1:0]   idle_ticks_reg, idle_ticks_next;

    logic [COUNT_W-1:0]  field_count_inc;
    logic [TICK_W-1:0]   ticks_inc;
    logic                taken;
    logic [EVENT_W-1:0]  ev;

    assign field_count_inc = field_count_reg + COUNT_W'(1);
    assign ticks_inc = (idle_ticks_reg != {TICK_W{1'b1}}) ?
                       idle_ticks_reg + TICK_W'(1) : idle_ticks_reg;
    assign taken = (req_type == REQ_BYTE) &&
                   !(phase_reg == PH_START && rx_byte != cfg.sof_byte);

    always_comb
    begin
        phase_next          = phase_reg;
        field_count_next    = field_count_reg;
        payload_length_next = payload_length_reg;
        running_sum_next    = running_sum_reg;
        frame_position_next = frame_position_reg;
        idle_ticks_next     = idle_ticks_reg;
        ev                  = EV_NONE;

        if (req_type == REQ_TICK)
        begin
            if (ticks_inc > cfg.timeout_ticks)
            begin
                idle_ticks_next = '0;
                if (phase_reg != PH_START)
                begin
                    ev = EV_TIMEOUT;
                end
            end
            else
            begin
                idle_ticks_next = ticks_inc;
            end
        end
        else
        begin
            idle_ticks_next = '0;
            if (taken)
            begin
                case (phase_reg)
                    PH_START: phase_next = PH_TYPE;
                    PH_TYPE:
                    begin
                        phase_next       = PH_ADDR;
                        field_count_next = '0;
                    end
                    PH_ADDR:
                    begin
                        field_count_next = field_count_inc;
                        if (field_count_inc >= COUNT_W'(ADDRESS_BYTES))
                        begin
                            field_count_next = '0;
                            phase_next       = PH_CTRL;
                        end
                    end
                    PH_CTRL: phase_next = PH_LEN;
                    PH_LEN:
                    begin
                        payload_length_next = rx_byte;
                        field_count_next    = '0;
                        phase_next          = (rx_byte != '0) ? PH_DATA : PH_SUM;
                    end
                    PH_DATA:
                    begin
                        field_count_next = field_count_inc;
                        if (field_count_inc >= payload_length_reg)
                        begin
                            field_count_next = '0;
                            phase_next       = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        if (rx_byte == running_sum_reg)
                        begin
                            phase_next = PH_END;
                        end
                        else
                        begin
                            ev = EV_SUM_ERR;
                        end
                    end
                    default:
                        ev = (rx_byte == cfg.eof_byte) ? EV_FRAME_OK : EV_END_ERR;
                endcase
                running_sum_next    = running_sum_reg + rx_byte;
                frame_position_next = frame_position_reg + POS_W'(1);
            end
        end

        // Any event closes the frame: return to hunting for a start mark
        if (ev != EV_NONE)
        begin
            phase_next          = PH_START;
            field_count_next    = '0;
            payload_length_next = '0;
            running_sum_next    = '0;
            frame_position_next = '0;
        end
    end

    always_comb
    begin
        result.byte_valid  = taken;
        result.byte_value  = taken ? rx_byte : '0;
        result.byte_class  = taken ? CLASS_W'(phase_reg) : CLS_START;
        result.byte_index  = taken ? frame_position_reg : '0;
        result.frame_event = ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_START;
            field_count_reg    <= '0;
            payload_length_reg <= '0;
            running_sum_reg    <= '0;
            frame_position_reg <= '0;
            idle_ticks_reg     <= '0;
        end
        else if (load)
        begin
            phase_reg          <= phase_next;
            field_count_reg    <= field_count_next;
            payload_length_reg <= payload_length_next;
            running_sum_reg    <= running_sum_next;
            frame_position_reg <= frame_position_next;
            idle_ticks_reg     <= idle_ticks_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_START |-> running_sum_reg == '0 && frame_position_reg == '0
            && field_count_reg == '0)
        else $error("frame state not cleared while hunting for start mark");

    a_addr_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ADDR |-> field_count_reg < COUNT_W'(ADDRESS_BYTES))
        else $error("address count overran the address field");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> field_count_reg < payload_length_reg)
        else $error("data count overran the payload length");

    a_tick_keeps_frame: assert property (@(posedge clk) disable iff (!rst_n)
        load && req_type == REQ_TICK && result.frame_event == EV_NONE
            |=> $stable(phase_reg) && $stable(frame_position_reg))
        else $error("tick without timeout disturbed the frame state");
`endif

endmodule

// ===== rtl/mfr_out_stage.sv =====
// Result register with the output handshake of the meter frame receiver.
module mfr_out_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  mfr_pkg::result_t              result,
    output logic                          ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mfr_pkg::OUT_DAT_W-1:0] m_tdata,
    output logic                          m_tuser
);
    import mfr_pkg::*;

    localparam int PAD_W = OUT_DAT_W - BYTE_W - CLASS_W - POS_W - EVENT_W;

    logic    valid_reg;
    result_t data_reg;

    // Take a new result whenever the held one is gone or leaves this cycle
    assign ready = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.byte_valid;
    assign m_tdata  = {{PAD_W{1'b0}}, data_reg.frame_event, data_reg.byte_index,
                       data_reg.byte_class, data_reg.byte_value};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for meter_frame_receiver: directed table, then random frames.
module tb_top;
    import mfr_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_ITEMS    = 1100;
    localparam int HOLD_OFF_CYCLES = 400;
    // Spare cycles waited out before a register write or the end check
    localparam int DRAIN_CYCLES    = 4;
    // Slowest run: about 3000 transactions (tick bursts included), each waiting
    // out the longest source gap and the longest sink stall, plus the hold-off.
    // Take that several times over.
    localparam int CYCLE_LIMIT     = 1_000_000;

    // Index past the last register; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam result_t NO_RESULT = '0;

    typedef enum logic [2:0] {
        ROW_BYTE,
        ROW_TICK,
        ROW_SUM_GOOD,
        ROW_SUM_BAD,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table. Rows marked typed carry a hand-written
    // expectation; all others are checked against the in-bench parser.
    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_sel;
        logic [CFG_DAT_W-1:0]   value;
        bit                     typed;
        result_t                want;
    } stim_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;   // [7:0] rx_byte
    logic                  s_tuser   = 1'b0; // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [7:0] byte_value, [10:8] byte_class, [19:11] byte_index,
    // [22:20] frame_event, [23] zero
    logic [OUT_DAT_W-1:0]  m_tdata;
    logic                  m_tuser;          // [0] byte_valid
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;

    // Parser state mirrored by the bench, starting at its reset values
    logic [CLASS_W-1:0]    exp_phase = CLS_START;
    logic [COUNT_W-1:0]    exp_count = '0;
    logic [COUNT_W-1:0]    exp_len   = '0;
    logic [BYTE_W-1:0]     exp_sum   = '0;
    logic [POS_W-1:0]      exp_pos   = '0;
    logic [TICK_W-1:0]     exp_idle  = '0;

    // Register copies, tracked on every write
    logic [BYTE_W-1:0]     cur_start   = SOF_BYTE_RST;
    logic [BYTE_W-1:0]     cur_end     = EOF_BYTE_RST;
    logic [TICK_W-1:0]     cur_timeout = TIMEOUT_RST;

    result_t echo_queue[$];
    int      items_sent   = 0;
    int      error_count  = 0;
    int      cycle_count  = 0;
    bit      src_steady   = 1'b0;
    bit      hold_off_req = 1'b0;

    meter_frame_receiver uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Drop the current frame and go back to hunting for a start mark.
    function automatic void abandon_frame();
        exp_phase = CLS_START;
        exp_count = '0;
        exp_len   = '0;
        exp_sum   = '0;
        exp_pos   = '0;
    endfunction

    // Advance the mirrored parser by one input transaction and return the
    // result it must produce.
    function automatic result_t parse_rx_item(input logic req, input logic [BYTE_W-1:0] b);
        result_t r;
        r = NO_RESULT;
        if (req == REQ_TICK)
        begin
            // Idle counter saturates; exceeding the timeout clears it and
            // aborts a partial frame, but raises nothing while hunting
            if (exp_idle != '1)
                exp_idle = exp_idle + 1'b1;
            if (exp_idle > cur_timeout)
            begin
                exp_idle = '0;
                if (exp_phase != CLS_START)
                begin
                    abandon_frame();
                    r.frame_event = EV_TIMEOUT;
                end
            end
        end
        else
        begin
            exp_idle = '0;
            // Bytes other than the start mark are dropped while hunting
            if (exp_phase != CLS_START || b == cur_start)
            begin
                r.byte_valid = 1'b1;
                r.byte_value = b;
                r.byte_class = exp_phase;
                r.byte_index = exp_pos;
                case (exp_phase)
                    CLS_START:
                        exp_phase = CLS_TYPE;
                    CLS_TYPE:
                    begin
                        exp_phase = CLS_ADDR;
                        exp_count = '0;
                    end
                    CLS_ADDR:
                    begin
                        exp_count = exp_count + 1'b1;
                        if (exp_count >= ADDRESS_BYTES)
                        begin
                            exp_count = '0;
                            exp_phase = CLS_CTRL;
                        end
                    end
                    CLS_CTRL:
                        exp_phase = CLS_LEN;
                    CLS_LEN:
                    begin
                        // Zero length skips the data field
                        exp_len   = b;
                        exp_count = '0;
                        exp_phase = (b != '0) ? CLS_DATA : CLS_SUM;
                    end
                    CLS_DATA:
                    begin
                        exp_count = exp_count + 1'b1;
                        if (exp_count >= exp_len)
                        begin
                            exp_count = '0;
                            exp_phase = CLS_SUM;
                        end
                    end
                    CLS_SUM:
                    begin
                        if (b == exp_sum)
                            exp_phase = CLS_END;
                        else
                            r.frame_event = EV_SUM_ERR;
                    end
                    default:
                        r.frame_event = (b == cur_end) ? EV_FRAME_OK : EV_END_ERR;
                endcase
                if (r.frame_event != EV_NONE)
                    abandon_frame();
                else
                begin
                    exp_sum = exp_sum + b;
                    exp_pos = exp_pos + 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Offer one item after a random gap, hold it until the block takes it,
    // then queue the result it must cause. Leave tvalid high on return.
    task automatic send_item(input logic req, input logic [BYTE_W-1:0] b,
                             input bit typed, input result_t want);
        int gap;
        int r;
        result_t predicted;
        if (src_steady)
            gap = 0;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        // Lower tvalid only across a real gap, so a back-to-back item never
        // sees two assignments in one step
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = parse_rx_item(req, b);
        echo_queue.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Send a run of ticks; the byte lane carries junk the block must ignore.
    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_item(REQ_TICK, 8'($urandom), 1'b0, NO_RESULT);
    endtask

    // Write one register once the block has drained every pending result.
    task automatic load_register(input logic [CFG_IDX_W-1:0] sel,
                                 input logic [CFG_DAT_W-1:0] val);
        s_tvalid <= 1'b0;
        while (echo_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (sel)
            REG_SOF_BYTE: cur_start   = val[BYTE_W-1:0];
            REG_EOF_BYTE: cur_end     = val[BYTE_W-1:0];
            REG_TIMEOUT:  cur_timeout = val;
            default:      ;
        endcase
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.byte_valid  = m_tuser;
            got.byte_value  = m_tdata[7:0];
            got.byte_class  = m_tdata[10:8];
            got.byte_index  = m_tdata[19:11];
            got.frame_event = m_tdata[22:20];
            if (echo_queue.size() == 0)
            begin
                $error("result transaction with nothing expected: tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = echo_queue.pop_front();
                check_field("byte_valid", want.byte_valid, got.byte_valid);
                check_field("byte_value", want.byte_value, got.byte_value);
                check_field("byte_class", want.byte_class, got.byte_class);
                check_field("byte_index", want.byte_index, got.byte_index);
                check_field("frame_event", want.frame_event, got.frame_event);
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("meter_frame_receiver: mismatch");
            $finish;
        end
    end

    // Sink pacing: mostly short stalls, a few long ones, stretches of steady
    // ready, and one long hold-off on request so the result register backs up
    // and the block must drop s_tready while the source keeps offering.
    initial
    begin : sink_pacing
        int stall;
        int r;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end
            else if (r < 55)
                stall = 0;
            else if (r < 85)
                stall = $urandom_range(1, 3);
            else if (r < 97)
                stall = $urandom_range(4, 12);
            else
                stall = $urandom_range(20, 50);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ((r < 8) ? $urandom_range(50, 200) : $urandom_range(1, 4)) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        stim_row_t        rows[$];
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] frame_sum;
        logic [BYTE_W-1:0] pick;
        logic [TICK_W-1:0] tmo;
        int r;
        int plen;
        int cut;
        int frames_left;
        int rand_goal;
        bit pressure_done;

        // Defaults after reset: a tick and stray bytes produce empty results, and the start mark opens a frame
        rows.push_back('{ROW_TICK, '0, 16'h0000, 1'b1, NO_RESULT});
        rows.push_back('{ROW_BYTE, '0, 16'h0000, 1'b1, NO_RESULT});
        rows.push_back('{ROW_BYTE, '0, 16'h00FF, 1'b1, NO_RESULT});
        rows.push_back('{ROW_BYTE, '0, 16'(SOF_BYTE_RST), 1'b1,
                         result_t'{1'b1, SOF_BYTE_RST, CLS_START, 9'd0, EV_NONE}});
        // Start mark again inside the frame is just the type byte
        rows.push_back('{ROW_BYTE, '0, 16'(SOF_BYTE_RST), 1'b0, NO_RESULT});
        for (int k = 0; k < ADDRESS_BYTES; k++)
            rows.push_back('{ROW_BYTE, '0, (k % 2) ? 16'h00FF : 16'h0000, 1'b0, NO_RESULT});
        rows.push_back('{ROW_BYTE, '0, 16'h0081, 1'b0, NO_RESULT});
        // Zero length: checksum follows directly
        rows.push_back('{ROW_BYTE, '0, 16'h0000, 1'b0, NO_RESULT});
        rows.push_back('{ROW_SUM_GOOD, '0, 16'h0000, 1'b0, NO_RESULT});
        rows.push_back('{ROW_BYTE, '0, 16'(EOF_BYTE_RST), 1'b1,
                         result_t'{1'b1, EOF_BYTE_RST, CLS_END, 9'd12, EV_FRAME_OK}});
        // Extreme settings; upper data bits of the byte registers are junk
        rows.push_back('{ROW_CFG, REG_TIMEOUT, 16'h0000, 1'b0, NO_RESULT});
        rows.push_back('{ROW_CFG, REG_SOF_BYTE, 16'hFF00, 1'b0, NO_RESULT});
        rows.push_back('{ROW_CFG, REG_EOF_BYTE, 16'h00FF, 1'b0, NO_RESULT});
        // Zero timeout: the first tick inside a frame aborts it
        rows.push_back('{ROW_BYTE, '0, 16'h0000, 1'b1,
                         result_t'{1'b1, 8'h00, CLS_START, 9'd0, EV_NONE}});
        rows.push_back('{ROW_TICK, '0, 16'h00FF, 1'b1,
                         result_t'{1'b0, 8'h00, CLS_START, 9'd0, EV_TIMEOUT}});
        rows.push_back('{ROW_TICK, '0, 16'h0000, 1'b1, NO_RESULT});
        // One data byte, then a wrong checksum
        rows.push_back('{ROW_BYTE, '0, 16'h0000, 1'b0, NO_RESULT});
        for (int k = 0; k < ADDRESS_BYTES + 2; k++)
            rows.push_back('{ROW_BYTE, '0, 16'($urandom_range(0, 255)), 1'b0, NO_RESULT});
        rows.push_back('{ROW_BYTE, '0, 16'h0001, 1'b0, NO_RESULT});
        rows.push_back('{ROW_BYTE, '0, 16'h00FF, 1'b0, NO_RESULT});
        rows.push_back('{ROW_SUM_BAD, '0, 16'h0000, 1'b0, NO_RESULT});

        // Hold reset, then release it on an edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            case (rows[i].kind)
                ROW_CFG:
                    load_register(rows[i].reg_sel, rows[i].value);
                ROW_TICK:
                    send_item(REQ_TICK, rows[i].value[7:0], rows[i].typed, rows[i].want);
                ROW_SUM_GOOD:
                    send_item(REQ_BYTE, exp_sum, rows[i].typed, rows[i].want);
                ROW_SUM_BAD:
                    send_item(REQ_BYTE, exp_sum + 8'd1, rows[i].typed, rows[i].want);
                default:
                    send_item(REQ_BYTE, rows[i].value[7:0], rows[i].typed, rows[i].want);
            endcase
        end

        // Random part: phases of new settings, each a handful of frames with
        // noise, stray ticks, corrupted checksums or end marks and cut frames
        rand_goal = items_sent + RANDOM_ITEMS;
        pressure_done = 1'b0;
        while (items_sent < rand_goal)
        begin
            r = $urandom_range(0, 3);
            pick = (r == 0) ? SOF_BYTE_RST : (r == 1) ? 8'h00 : (r == 2) ? 8'hFF
                 : 8'($urandom);
            load_register(REG_SOF_BYTE, {8'($urandom), pick});
            r = $urandom_range(0, 3);
            pick = (r == 0) ? EOF_BYTE_RST : (r == 1) ? 8'h00 : (r == 2) ? 8'hFF
                 : 8'($urandom);
            load_register(REG_EOF_BYTE, {8'($urandom), pick});
            r = $urandom_range(0, 4);
            tmo = (r == 0) ? TIMEOUT_RST : (r == 1) ? 16'h0000 : (r == 2) ? 16'hFFFF
                : (r == 3) ? 16'($urandom_range(1, 30)) : 16'($urandom);
            load_register(REG_TIMEOUT, tmo);
            if ($urandom_range(0, 5) == 0)
                load_register(REG_UNUSED, 16'($urandom));
            src_steady = ($urandom_range(0, 3) == 0);

            // First phase: keep offering items until the sink begins its long
            // hold-off, so the block backs up while the source stays busy
            if (!pressure_done)
            begin
                pressure_done = 1'b1;
                hold_off_req  = 1'b1;
                while (hold_off_req)
                    send_item(REQ_BYTE, 8'($urandom), 1'b0, NO_RESULT);
            end

            frames_left = $urandom_range(3, 8);
            while (frames_left > 0 && items_sent < rand_goal)
            begin
                frames_left--;
                // Noise between frames
                repeat ($urandom_range(0, 3))
                    send_item(REQ_BYTE, 8'($urandom), 1'b0, NO_RESULT);
                send_ticks($urandom_range(0, 2));
                if ($urandom_range(0, 19) == 0)
                    send_ticks($urandom_range(50, 150));

                // Build a frame: start, type, address, control, length, data
                body.delete();
                body.push_back(cur_start);
                repeat (ADDRESS_BYTES + 2)
                    body.push_back(8'($urandom));
                r = $urandom_range(0, 99);
                if (r < 10)
                    plen = 0;
                else if (r < 85)
                    plen = $urandom_range(1, 8);
                else if (r < 97)
                    plen = $urandom_range(9, 40);
                else
                    plen = $urandom_range(200, 255);
                body.push_back(8'(plen));
                repeat (plen)
                    body.push_back(8'($urandom));
                frame_sum = '0;
                foreach (body[k])
                    frame_sum = frame_sum + body[k];
                body.push_back(($urandom_range(0, 99) < 85) ? frame_sum
                               : frame_sum + 8'($urandom_range(1, 255)));
                body.push_back(($urandom_range(0, 99) < 85) ? cur_end
                               : cur_end ^ 8'($urandom_range(1, 255)));

                // Now and then cut the frame short
                cut = ($urandom_range(0, 99) < 6) ? $urandom_range(1, body.size() - 1)
                    : body.size();
                for (int k = 0; k < cut; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 5 && cur_timeout >= 3)
                        send_ticks($urandom_range(1, 3));
                    else if (r == 5)
                        send_ticks((cur_timeout < 200) ? int'(cur_timeout) + 1 : 200);
                    send_item(REQ_BYTE, body[k], 1'b0, NO_RESULT);
                end
                if (cut < body.size() && $urandom_range(0, 1) == 1)
                    send_ticks((cur_timeout < 200) ? int'(cur_timeout) + 1 : 200);
            end
        end

        // Drain and report
        s_tvalid <= 1'b0;
        while (echo_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("meter_frame_receiver: match");
        else
            $display("meter_frame_receiver: mismatch");
        $finish;
    end

endmodule
